>>> rtl/lpht_pkg.sv
// Package for the linear probing hash table.
// Table geometry, operation codes and the slot record; no dependencies.
package lpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CFG_W       = 11;
    localparam int CAP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int COORD_W     = 32;
    localparam int KEY_W       = 2 * COORD_W;
    localparam int FLAGS_W     = 8;
    localparam int ID_W        = 16;
    localparam int COUNT_W     = 32;
    localparam int ENTRY_W     = 11;
    localparam int OP_W        = 2;

    // restoring remainder: bits retired per cycle
    localparam int DIV_BITS    = 4;
    localparam int DIV_ITERS   = COORD_W / DIV_BITS;
    localparam int DIV_CW      = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic               used;
        logic [FLAGS_W-1:0] flags;
        logic [ID_W-1:0]    id;
        logic [KEY_W-1:0]   key;
    } t_slot;

endpackage

>>> rtl/lpht_req_if.sv
// Request channel of the hash table: valid/ready plus operation and key payload.
// Depends on lpht_pkg.
interface lpht_req_if import lpht_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [COORD_W-1:0] key_x;
    logic signed [COORD_W-1:0] key_y;
    logic [FLAGS_W-1:0]        flags_in;
    logic [ID_W-1:0]           id_in;

    modport source (output valid, operation, key_x, key_y, flags_in, id_in, input ready);
    modport sink   (input valid, operation, key_x, key_y, flags_in, id_in, output ready);
endinterface

>>> rtl/lpht_rsp_if.sv
// Response channel of the hash table: valid/ready plus result and counters.
// Depends on lpht_pkg.
interface lpht_rsp_if import lpht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [FLAGS_W-1:0] flags_out;
    logic [ID_W-1:0]    id_out;
    logic               table_full;
    logic [COUNT_W-1:0] access_count;
    logic [COUNT_W-1:0] miss_count;
    logic [ENTRY_W-1:0] entry_count;

    modport source (output valid, found, flags_out, id_out, table_full, access_count,
                    miss_count, entry_count, input ready);
    modport sink   (input valid, found, flags_out, id_out, table_full, access_count,
                    miss_count, entry_count, output ready);
endinterface

>>> rtl/linear_probe_hash_table.sv
// Channel   Dir  Handshake       Payload
// i_req     in   valid/ready     operation, key_x, key_y, flags_in, id_in
// o_rsp     out  valid/ready     found, flags_out, id_out, table_full, counters
// i_cfg_*   in   write enable    capacity_in_use (11 bits)
//
// Insert/lookup: accept, remainder steps, then a slot read and a check per probed slot,
// up to two write-backs (moved home entry, new or found entry) and the result register
// load. The registered read of the slot RAM sets the probe rate.
// Clear: a sweep clears every slot. After reset the same sweep runs with i_req.ready
// low. One item is in work at a time; a new request is taken while the previous result
// still waits in the output register.
// Top level of the hash table; depends on lpht_pkg, lpht_req_if, lpht_rsp_if.
module linear_probe_hash_table import lpht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    lpht_req_if.sink         i_req,
    lpht_rsp_if.source       o_rsp
);

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_DIV, ST_RD, ST_CHK, ST_WR_AT, ST_WR_HOME, ST_DONE
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [CNT_W-1:0]   r_cap;
    t_op                r_op;
    logic [KEY_W-1:0]   r_key;
    logic [FLAGS_W-1:0] r_flags;
    logic [ID_W-1:0]    r_id;
    logic [CNT_W-1:0]   r_rem;
    logic [COORD_W-1:0] r_dvd;
    logic [DIV_CW-1:0]  r_div_cnt;
    logic [ADDR_W-1:0]  r_home;
    logic [ADDR_W-1:0]  r_at;
    logic [CNT_W-1:0]   r_n;
    logic               r_clr_rpt;
    t_slot              r_home_ent;
    t_slot              r_new;
    t_slot              r_rdata;
    logic               r_found;
    logic [FLAGS_W-1:0] r_res_flags;
    logic [ID_W-1:0]    r_res_id;
    logic               r_full;
    logic [COUNT_W-1:0] r_acc;
    logic [COUNT_W-1:0] r_miss;
    logic [CNT_W-1:0]   r_entries;

    logic               r_out_valid;
    logic               r_out_found;
    logic [FLAGS_W-1:0] r_out_flags;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_full;
    logic [COUNT_W-1:0] r_out_acc;
    logic [COUNT_W-1:0] r_out_miss;
    logic [ENTRY_W-1:0] r_out_entries;

    t_slot              mem [TABLE_DEPTH];

    logic [CAP_W-1:0]   cfg_ext;
    logic [CNT_W-1:0]   eff_cap;
    logic [CNT_W:0]     div_t;
    logic [CNT_W-1:0]   n_rem;
    logic [COORD_W-1:0] n_dvd;
    logic [CNT_W-1:0]   at_inc;
    logic [ADDR_W-1:0]  n_at;
    logic [CNT_W-1:0]   n_inc;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_slot              mem_wdata;
    logic               rsp_load;

    // capacity clamp to [2, TABLE_DEPTH]
    always_comb begin
        cfg_ext = CAP_W'(r_cfg);
        if (cfg_ext < CAP_W'(2)) begin
            eff_cap = CNT_W'(2);
        end else if (cfg_ext > CAP_W'(TABLE_DEPTH)) begin
            eff_cap = CNT_W'(TABLE_DEPTH);
        end else begin
            eff_cap = CNT_W'(cfg_ext);
        end
    end

    // DIV_BITS restoring remainder steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        div_t = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            div_t = {n_rem, n_dvd[COORD_W-1]};
            if (div_t >= {1'b0, r_cap}) begin
                div_t = div_t - {1'b0, r_cap};
            end
            n_rem = div_t[CNT_W-1:0];
            n_dvd = {n_dvd[COORD_W-2:0], 1'b0};
        end
    end

    assign at_inc = CNT_W'(r_at) + CNT_W'(1);
    assign n_at   = (at_inc >= r_cap) ? '0 : at_inc[ADDR_W-1:0];
    assign n_inc  = r_n + CNT_W'(1);

    always_comb begin
        mem_we    = (r_state == ST_CLR) || (r_state == ST_WR_AT) || (r_state == ST_WR_HOME);
        mem_waddr = (r_state == ST_WR_HOME) ? r_home : r_at;
        case (r_state)
            ST_WR_AT:   mem_wdata = r_home_ent;
            ST_WR_HOME: mem_wdata = r_new;
            default:    mem_wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_at];
    end

    assign rsp_load = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_cfg       <= CFG_W'(1024);
            r_at        <= '0;
            r_clr_rpt   <= 1'b0;
            r_acc       <= '0;
            r_miss      <= '0;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (o_rsp.ready && !rsp_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    if (r_at == ADDR_W'(TABLE_DEPTH - 1)) begin
                        r_at      <= '0;
                        r_entries <= '0;
                        r_state   <= r_clr_rpt ? ST_DONE : ST_IDLE;
                    end else begin
                        r_at <= r_at + ADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_op        <= t_op'(i_req.operation);
                        r_key       <= {i_req.key_x, i_req.key_y};
                        r_flags     <= i_req.flags_in;
                        r_id        <= i_req.id_in;
                        r_cap       <= eff_cap;
                        r_found     <= 1'b0;
                        r_res_flags <= '0;
                        r_res_id    <= '0;
                        r_full      <= 1'b0;
                        case (t_op'(i_req.operation))
                            OP_INSERT, OP_LOOKUP: begin
                                r_acc     <= r_acc + COUNT_W'(1);
                                r_dvd     <= i_req.key_x ^ i_req.key_y;
                                r_rem     <= '0;
                                r_div_cnt <= '0;
                                r_state   <= ST_DIV;
                            end
                            OP_CLEAR: begin
                                r_at      <= '0;
                                r_clr_rpt <= 1'b1;
                                r_state   <= ST_CLR;
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem     <= n_rem;
                    r_dvd     <= n_dvd;
                    r_div_cnt <= r_div_cnt + DIV_CW'(1);
                    if (r_div_cnt == DIV_CW'(DIV_ITERS - 1)) begin
                        r_home  <= n_rem[ADDR_W-1:0];
                        r_at    <= n_rem[ADDR_W-1:0];
                        r_n     <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_n == '0) begin
                        r_home_ent <= r_rdata;
                    end
                    if (!r_rdata.used) begin
                        if (r_op == OP_INSERT) begin
                            r_new     <= '{used: 1'b1, flags: r_flags, id: r_id, key: r_key};
                            r_entries <= r_entries + CNT_W'(1);
                            if (r_n != '0) begin
                                r_miss  <= r_miss + COUNT_W'(1);
                                r_state <= ST_WR_AT;
                            end else begin
                                r_state <= ST_WR_HOME;
                            end
                        end else begin
                            if (r_n != '0) begin
                                r_miss <= r_miss + COUNT_W'(1);
                            end
                            r_state <= ST_DONE;
                        end
                    end else if (r_op == OP_LOOKUP && r_rdata.key == r_key) begin
                        r_found     <= 1'b1;
                        r_res_flags <= r_rdata.flags;
                        r_res_id    <= r_rdata.id;
                        r_new       <= r_rdata;
                        if (r_n != '0) begin
                            r_miss  <= r_miss + COUNT_W'(1);
                            r_state <= ST_WR_AT;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_n  <= n_inc;
                        r_at <= n_at;
                        if (n_inc >= r_cap) begin
                            r_miss  <= r_miss + COUNT_W'(1);
                            r_full  <= (r_op == OP_INSERT);
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_WR_AT: begin
                    r_state <= ST_WR_HOME;
                end
                ST_WR_HOME: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (rsp_load) begin
                        r_clr_rpt     <= 1'b0;
                        r_out_valid   <= 1'b1;
                        r_out_found   <= r_found;
                        r_out_flags   <= r_res_flags;
                        r_out_id      <= r_res_id;
                        r_out_full    <= r_full;
                        r_out_acc     <= r_acc;
                        r_out_miss    <= r_miss;
                        r_out_entries <= ENTRY_W'(r_entries);
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.flags_out    = r_out_flags;
    assign o_rsp.id_out       = r_out_id;
    assign o_rsp.table_full   = r_out_full;
    assign o_rsp.access_count = r_out_acc;
    assign o_rsp.miss_count   = r_out_miss;
    assign o_rsp.entry_count  = r_out_entries;

endmodule

>>> rtl/lpht_checker.sv
// Port-level checks for linear_probe_hash_table, attached by bind.
// Depends on lpht_pkg.
module lpht_checker import lpht_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_found,
    input logic [FLAGS_W-1:0] i_flags_out,
    input logic [ID_W-1:0]    i_id_out,
    input logic               i_table_full,
    input logic [COUNT_W-1:0] i_access_count,
    input logic [COUNT_W-1:0] i_miss_count,
    input logic [ENTRY_W-1:0] i_entry_count
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_found)
            && $stable(i_flags_out) && $stable(i_id_out) && $stable(i_table_full)
            && $stable(i_access_count) && $stable(i_miss_count) && $stable(i_entry_count))
        else $error("response changed while stalled");

    // payload of a miss is zero, and a hit is never a full-table reject
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_found |-> i_flags_out == '0 && i_id_out == '0)
        else $error("flags or id nonzero without a hit");

    a_hit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_found |-> !i_table_full)
        else $error("hit reported together with table_full");

    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ENTRY_W'(i_entry_count) <= ENTRY_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // clear sweep after reset keeps requests out
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request accepted during reset sweep");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_found        (o_rsp.found),
    .i_flags_out    (o_rsp.flags_out),
    .i_id_out       (o_rsp.id_out),
    .i_table_full   (o_rsp.table_full),
    .i_access_count (o_rsp.access_count),
    .i_miss_count   (o_rsp.miss_count),
    .i_entry_count  (o_rsp.entry_count)
);

>>> test/lpht_checker.sv
`timescale 1ns / 1ps
// Checker for the linear probing hash table: watches the config port and both channels,
// predicts each result from its own copy of the table and compares. Depends on lpht_pkg.
module lpht_tb_checker import lpht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    lpht_req_if              i_req,
    lpht_rsp_if              i_rsp,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_hits,
    output int               o_rejects
);

    typedef struct packed {
        logic               found;
        logic [FLAGS_W-1:0] flags;
        logic [ID_W-1:0]    id;
        logic               full;
        logic [COUNT_W-1:0] accesses;
        logic [COUNT_W-1:0] misses;
        logic [ENTRY_W-1:0] entries;
    } t_table_result;

    t_slot              slot_mirror [TABLE_DEPTH];
    logic [CFG_W-1:0]   cap_mirror;
    logic [COUNT_W-1:0] access_total;
    logic [COUNT_W-1:0] miss_total;
    logic [ENTRY_W-1:0] entry_total;
    t_table_result      owed_results [$];
    int                 fail_total    = 0;
    int                 checked_total = 0;
    int                 hit_total     = 0;
    int                 reject_total  = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;
    assign o_hits       = hit_total;
    assign o_rejects    = reject_total;

    function automatic int unsigned next_slot(input int unsigned at, input int unsigned span);
        return (at + 1 >= span) ? 0 : at + 1;
    endfunction

    task automatic table_op(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] kx,
                            input logic [COORD_W-1:0] ky, input logic [FLAGS_W-1:0] fl,
                            input logic [ID_W-1:0] idv, output t_table_result res);
        int unsigned      span;
        int unsigned      home;
        int unsigned      at;
        int unsigned      n;
        logic             probed;
        t_slot            held;
        logic [KEY_W-1:0] key;
        res    = '0;
        probed = 1'b0;
        key    = {kx, ky};
        span   = cap_mirror;
        if (span < 2) span = 2;
        if (span > TABLE_DEPTH) span = TABLE_DEPTH;
        home = (kx ^ ky) % span;
        at   = home;
        n    = 0;
        case (op)
            OP_INSERT: begin
                access_total++;
                while (n < span && slot_mirror[at].used) begin
                    at = next_slot(at, span);
                    n++;
                end
                if (n >= span) begin
                    miss_total++;
                    res.full = 1'b1;
                end else begin
                    // old home occupant moves to the free slot
                    if (at != home) begin
                        miss_total++;
                        slot_mirror[at] = slot_mirror[home];
                    end
                    slot_mirror[home] = '{used: 1'b1, flags: fl, id: idv, key: key};
                    entry_total++;
                end
            end
            OP_LOOKUP: begin
                access_total++;
                while (n < span && slot_mirror[at].used && !res.found) begin
                    if (slot_mirror[at].key == key) begin
                        if (at != home) begin
                            miss_total++;
                            held              = slot_mirror[at];
                            slot_mirror[at]   = slot_mirror[home];
                            slot_mirror[home] = held;
                        end
                        res.found = 1'b1;
                        res.flags = slot_mirror[home].flags;
                        res.id    = slot_mirror[home].id;
                    end else begin
                        at     = next_slot(at, span);
                        probed = 1'b1;
                        n++;
                    end
                end
                if (!res.found && probed) miss_total++;
            end
            OP_CLEAR: begin
                for (int s = 0; s < TABLE_DEPTH; s++) begin
                    slot_mirror[s].used  = 1'b0;
                    slot_mirror[s].flags = '0;
                    slot_mirror[s].id    = '0;
                end
                entry_total = '0;
            end
            default: ;
        endcase
        res.accesses = access_total;
        res.misses   = miss_total;
        res.entries  = entry_total;
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        t_table_result next_want;
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_DEPTH; s++) slot_mirror[s] = '0;
            cap_mirror   = TABLE_DEPTH;
            access_total = '0;
            miss_total   = '0;
            entry_total  = '0;
            owed_results.delete();
        end else begin
            if (i_cfg_we) cap_mirror = i_cfg_data;
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_total++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("found", want.found, i_rsp.found);
                    check_field("flags_out", want.flags, i_rsp.flags_out);
                    check_field("id_out", want.id, i_rsp.id_out);
                    check_field("table_full", want.full, i_rsp.table_full);
                    check_field("access_count", want.accesses, i_rsp.access_count);
                    check_field("miss_count", want.misses, i_rsp.miss_count);
                    check_field("entry_count", want.entries, i_rsp.entry_count);
                    checked_total++;
                    if (want.found) hit_total++;
                    if (want.full) reject_total++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                table_op(i_req.operation, i_req.key_x, i_req.key_y, i_req.flags_in,
                         i_req.id_in, next_want);
                owed_results.push_back(next_want);
            end
        end
        o_pending <= owed_results.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top of the hash table testbench: clock, reset, capacity writes and request stimulus.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if, linear_probe_hash_table, lpht_tb_checker.
module testbench;
    import lpht_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int SEG_COUNT    = 10;
    localparam int SEG_ITEMS    = 125;
    localparam int POOL_N       = 64;
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 16;
    localparam int SEG_CAP [SEG_COUNT] = '{16, 3, 1024, 61, 1025, 200, 2, 97, 1024, 33};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;
    int               fail_count;
    int               pending;
    int               checked;
    int               hits;
    int               rejects;
    int               send_idle_pct = 19;
    int               recv_idle_pct = 82;
    int               sent          = 0;
    int               cap_writes    = 0;
    logic [COORD_W-1:0] pool_x [POOL_N];
    logic [COORD_W-1:0] pool_y [POOL_N];
    int               pool_fill     = 0;
    int               pool_next     = 0;

    lpht_req_if req_ch();
    lpht_rsp_if rsp_ch();

    linear_probe_hash_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    lpht_tb_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_rejects    (rejects)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // valid stays high into the next transfer unless an idle cycle is drawn
    task automatic send_req(input t_op op, input logic [COORD_W-1:0] kx,
                            input logic [COORD_W-1:0] ky, input logic [FLAGS_W-1:0] fl,
                            input logic [ID_W-1:0] idv);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key_x     <= kx;
        req_ch.key_y     <= ky;
        req_ch.flags_in  <= fl;
        req_ch.id_in     <= idv;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_writes++;
    endtask

    initial begin
        int                 done;
        int                 roll;
        int                 pick;
        int                 reuse_pct;
        t_op                op;
        logic [COORD_W-1:0] kx;
        logic [COORD_W-1:0] ky;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_NONE;
        req_ch.key_x     <= '0;
        req_ch.key_y     <= '0;
        req_ch.flags_in  <= '0;
        req_ch.id_in     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full capacity from reset
        send_req(OP_LOOKUP, 32'd1, 32'd2, 8'h00, 16'h0000);
        send_req(OP_INSERT, 32'd0, 32'd0, 8'h00, 16'h0000);
        send_req(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF, 16'hFFFF);
        send_req(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 8'hA5, 16'h5A5A);
        send_req(OP_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 16'h0000);
        send_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_03FF, 8'h00, 16'h0000);
        send_req(OP_INSERT, 32'd0, 32'd0, 8'h3C, 16'h1234);
        send_req(OP_LOOKUP, 32'd0, 32'd0, 8'hFF, 16'hFFFF);
        send_req(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_req(OP_CLEAR, 32'd0, 32'd0, 8'h00, 16'h0000);
        send_req(OP_LOOKUP, 32'd0, 32'd0, 8'h00, 16'h0000);
        // capacity below range: full table, full wrap on lookup
        write_capacity(11'd0);
        send_req(OP_INSERT, 32'd1, 32'd0, 8'h11, 16'h0111);
        send_req(OP_INSERT, 32'd2, 32'd0, 8'h22, 16'h0222);
        send_req(OP_INSERT, 32'd3, 32'd0, 8'h33, 16'h0333);
        send_req(OP_LOOKUP, 32'd5, 32'd0, 8'h00, 16'h0000);
        send_req(OP_LOOKUP, 32'd1, 32'd0, 8'h00, 16'h0000);
        // capacity above range: earlier entries stay stored
        write_capacity(11'h7FF);
        send_req(OP_INSERT, 32'hFFFF_FFFF, 32'd0, 8'h44, 16'h0444);
        send_req(OP_LOOKUP, 32'd2, 32'd0, 8'h00, 16'h0000);
        write_capacity(11'd1);
        send_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 8'h00, 16'h0000);
        send_req(OP_INSERT, 32'd4, 32'd4, 8'h55, 16'h0555);

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == 4) begin
                send_idle_pct = 82;
                recv_idle_pct <= 19;
            end else if (seg == 7) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            write_capacity(CFG_W'(SEG_CAP[seg]));
            done = 0;
            while (done < SEG_ITEMS) begin
                if ($urandom_range(199) == 0) wait_drained();
                roll = $urandom_range(99);
                if (roll < 44) op = OP_INSERT;
                else if (roll < 92) op = OP_LOOKUP;
                else if (roll < 96) op = OP_CLEAR;
                else op = OP_NONE;
                reuse_pct = (op == OP_INSERT) ? 25 : 70;
                if (pool_fill > 0 && $urandom_range(99) < reuse_pct) begin
                    pick = $urandom_range(pool_fill - 1);
                    kx   = pool_x[pick];
                    ky   = pool_y[pick];
                end else begin
                    kx = $urandom;
                    case ($urandom_range(9))
                        0: kx = 32'h8000_0000;
                        1: kx = 32'h7FFF_FFFF;
                        default: ;
                    endcase
                    // keys near home slot zero pile up into long probe runs
                    ky = $urandom_range(1) ? $urandom : kx ^ $urandom_range(0, 15);
                    if (op == OP_INSERT) begin
                        pool_x[pool_next] = kx;
                        pool_y[pool_next] = ky;
                        pool_next = (pool_next + 1) % POOL_N;
                        if (pool_fill < POOL_N) pool_fill++;
                    end
                end
                send_req(op, kx, ky, FLAGS_W'($urandom), ID_W'($urandom));
                if (op != OP_NONE) done++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d requests over %0d capacity settings, %0d results compared",
                 sent, cap_writes + 1, checked);
        $display("summary: %0d lookup hits, %0d inserts refused on a full table", hits, rejects);
        if (fail_count == 0 && pending == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
